// ----- rtl/msrng_pkg.sv -----
package msrng_pkg;
    localparam int STREAMS = 12;
    localparam int SIDX_W = $clog2(STREAMS);
    localparam int UNIT_SCALE = 1000;
    localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] STREAM_SALT = 64'hA5A5A5A5A5A5A5A5;
    localparam logic [63:0] MIX_M1 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_M2 = 64'h94D049BB133111EB;
    localparam logic [63:0] NORM_MOD = 64'd1001;
    localparam logic [63:0] NORM_OFS = 64'd6000;
    localparam int NORM_DRAWS = 12;

    // constant moduli: 2^32 mod m for folding, floor(2^40 / m) for the quotient estimate
    localparam logic [63:0] UNIT_MOD = 64'(UNIT_SCALE);
    localparam logic [63:0] NORM_FOLD = (64'd1 << 32) % NORM_MOD;
    localparam logic [63:0] UNIT_FOLD = (64'd1 << 32) % UNIT_MOD;
    localparam logic [63:0] NORM_RECIP = (64'd1 << 40) / NORM_MOD;
    localparam logic [63:0] UNIT_RECIP = (64'd1 << 40) / UNIT_MOD;

    localparam logic [2:0] KIND_RAW = 3'd0;
    localparam logic [2:0] KIND_RANGE = 3'd1;
    localparam logic [2:0] KIND_UNIT = 3'd2;
    localparam logic [2:0] KIND_NORMAL = 3'd3;
    localparam logic [2:0] KIND_CHANCE = 3'd4;
    localparam logic [2:0] KIND_PICK = 3'd5;
    localparam logic [2:0] KIND_RESEED = 3'd6;

    localparam logic [0:0] CFG_ROOT_SEED = 1'd0;
    localparam logic [0:0] CFG_SEED_TICK = 1'd1;
endpackage

// ----- rtl/multi_stream_splitmix_rng.sv -----
// Twelve SplitMix64 streams behind one request/result stream. A request is
// taken only while the block is idle and no result is waiting. Every 64-bit
// multiply goes through one shared 32x32 multiplier, three partial products
// a multiply. A modulo by the range span or the pick count runs one remainder
// bit a cycle; the modulo by 1001 or 1000 folds the draw twice, estimates the
// quotient with one reciprocal multiply and corrects once. A normal result
// sums twelve draws, a reseed works through every stream in turn, and a
// request that needs no draw goes straight to the output register. The result
// waits in that register; the next request is taken the cycle after it has
// been delivered.
module multi_stream_splitmix_rng import msrng_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [207:0] s_tdata,   // kind[2:0], stream[6:3], low_bound[70:7],
                                    // high_bound[134:71], probability[166:135],
                                    // pick_count[198:167], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // value[63:0]
    output logic         m_tuser,   // hit
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [63:0]  cfg_wdata
);
    localparam logic [3:0] ST_IDLE = 4'd0, ST_DRAW = 4'd1, ST_MIX0 = 4'd2,
        ST_MUL1 = 4'd3, ST_MIX1 = 4'd4, ST_MUL2 = 4'd5, ST_MIXD = 4'd6,
        ST_DIV = 4'd7, ST_POST = 4'd8, ST_OUT = 4'd9, ST_RSMUL = 4'd10,
        ST_RSMIX = 4'd11, ST_FOLD = 4'd12, ST_RMUL = 4'd13, ST_FIX = 4'd14;

    logic [63:0] root_seed_reg, seed_tick_reg;
    logic [63:0] state_reg [STREAMS];
    logic [63:0] count_reg [STREAMS];
    logic [3:0]  st_reg;
    logic [2:0]  kind_reg;
    logic [SIDX_W-1:0] sidx_reg;
    logic [63:0] lo_reg, hi_reg, cnt_reg, z_reg, acc_reg, div_reg, rem_reg, quo_reg;
    logic signed [31:0] prob_reg;
    logic [6:0]  bit_reg;
    logic [3:0]  ndraw_reg;
    logic [1:0]  rsph_reg;
    logic        mul_start, mul_done;
    logic [63:0] mul_a, mul_b, mul_p;
    logic [63:0] span;
    logic [64:0] rem_sh;
    logic [2:0]  in_kind;
    logic [3:0]  in_stream;
    logic [63:0] in_lo, in_hi;
    logic signed [31:0] in_prob;
    logic [31:0] in_cnt;
    logic [63:0] cmod, crecip, cfold, fold_src;
    logic [42:0] fold_val;
    logic [33:0] qd;

    assign in_kind = s_tdata[2:0];
    assign in_stream = s_tdata[6:3];
    assign in_lo = s_tdata[70:7];
    assign in_hi = s_tdata[134:71];
    assign in_prob = s_tdata[166:135];
    assign in_cnt = s_tdata[198:167];
    assign s_tready = (st_reg == ST_IDLE) && !m_tvalid;
    assign span = hi_reg - lo_reg + 64'd1;
    assign rem_sh = {rem_reg, quo_reg[63]};

    // constant modulus path: x = hi32 * (2^32 mod m) + lo32 keeps x mod m
    assign cmod = (kind_reg == KIND_NORMAL) ? NORM_MOD : UNIT_MOD;
    assign crecip = (kind_reg == KIND_NORMAL) ? NORM_RECIP : UNIT_RECIP;
    assign cfold = (kind_reg == KIND_NORMAL) ? NORM_FOLD : UNIT_FOLD;
    assign fold_src = (st_reg == ST_FOLD) ? rem_reg : z_reg;
    assign fold_val = 43'(fold_src[63:32]) * 43'(cfold[9:0]) + 43'(fold_src[31:0]);
    assign qd = 34'(mul_p[63:40]) * 34'(cmod[9:0]);

    msrng_mul u_mul (.aclk, .aresetn, .start(mul_start), .op_a(mul_a), .op_b(mul_b),
        .done(mul_done), .prod(mul_p));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            m_tvalid <= 1'b0;
            root_seed_reg <= '0;
            seed_tick_reg <= '0;
            for (int i = 0; i < STREAMS; i++) begin
                state_reg[i] <= '0;
                count_reg[i] <= '0;
            end
            mul_start <= 1'b0;
        end else begin
            mul_start <= 1'b0;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_ROOT_SEED: root_seed_reg <= cfg_wdata;
                    CFG_SEED_TICK: seed_tick_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            unique case (st_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        kind_reg <= in_kind;
                        lo_reg <= in_lo;
                        hi_reg <= in_hi;
                        prob_reg <= in_prob;
                        cnt_reg <= {32'd0, in_cnt};
                        acc_reg <= '0;
                        ndraw_reg <= '0;
                        m_tuser <= 1'b0;
                        m_tdata <= '0;
                        st_reg <= ST_DRAW;
                        if (in_kind == KIND_RESEED)
                            sidx_reg <= '0;
                        else
                            sidx_reg <= (in_stream >= 4'(STREAMS)) ? '0 : SIDX_W'(in_stream);
                        unique case (in_kind) inside
                            KIND_RANGE: if ($signed(in_hi) <= $signed(in_lo)) begin
                                m_tdata <= in_lo;
                                st_reg <= ST_OUT;
                            end
                            KIND_CHANCE: if (in_prob >= UNIT_SCALE || in_prob <= 32'sd0) begin
                                m_tuser <= (in_prob >= UNIT_SCALE);
                                st_reg <= ST_OUT;
                            end
                            KIND_PICK: if (in_cnt == 32'd0) st_reg <= ST_OUT;
                            KIND_RESEED: begin
                                rsph_reg <= 2'd0;
                                mul_a <= seed_tick_reg;
                                mul_b <= GOLDEN;
                                mul_start <= 1'b1;
                                st_reg <= ST_RSMUL;
                            end
                            KIND_RAW, KIND_UNIT, KIND_NORMAL: ;
                            default: st_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_DRAW: begin
                    state_reg[sidx_reg] <= state_reg[sidx_reg] + GOLDEN;
                    count_reg[sidx_reg] <= count_reg[sidx_reg] + 64'd1;
                    z_reg <= state_reg[sidx_reg] + GOLDEN;
                    st_reg <= ST_MIX0;
                end
                ST_MIX0: begin
                    mul_a <= z_reg ^ (z_reg >> 30);
                    mul_b <= MIX_M1;
                    mul_start <= 1'b1;
                    st_reg <= ST_MUL1;
                end
                ST_MUL1: if (mul_done) begin
                    mul_a <= mul_p ^ (mul_p >> 27);
                    mul_b <= MIX_M2;
                    mul_start <= 1'b1;
                    st_reg <= ST_MIX1;
                end
                ST_MIX1: if (mul_done) begin
                    z_reg <= mul_p ^ (mul_p >> 31);
                    st_reg <= (kind_reg == KIND_RESEED) ? ST_RSMIX : ST_MIXD;
                end
                ST_MIXD: begin
                    // pick the divisor, start the constant-modulus fold, or finish at once
                    quo_reg <= z_reg;
                    rem_reg <= '0;
                    bit_reg <= '0;
                    st_reg <= ST_DIV;
                    case (kind_reg)
                        KIND_RANGE: begin
                            div_reg <= span;
                            if (span == 64'd0) begin
                                m_tdata <= lo_reg + z_reg;
                                st_reg <= ST_OUT;
                            end
                        end
                        KIND_NORMAL, KIND_CHANCE: begin
                            rem_reg <= 64'(fold_val);
                            st_reg <= ST_FOLD;
                        end
                        KIND_PICK: div_reg <= cnt_reg;
                        KIND_UNIT: begin
                            m_tdata <= 64'((z_reg[63:44] * 30'(UNIT_SCALE)) >> 20);
                            st_reg <= ST_OUT;
                        end
                        default: begin
                            m_tdata <= z_reg;
                            st_reg <= ST_OUT;
                        end
                    endcase
                end
                ST_FOLD: begin
                    // second fold leaves under 33 bits; estimate the quotient
                    rem_reg <= 64'(fold_val);
                    mul_a <= 64'(fold_val);
                    mul_b <= crecip;
                    mul_start <= 1'b1;
                    st_reg <= ST_RMUL;
                end
                ST_RMUL: if (mul_done) begin
                    // the estimate is low by at most one
                    rem_reg <= rem_reg - {30'd0, qd};
                    st_reg <= ST_FIX;
                end
                ST_FIX: begin
                    if (rem_reg >= cmod) rem_reg <= rem_reg - cmod;
                    st_reg <= ST_POST;
                end
                ST_DIV: begin
                    // restoring divide, remainder only, one dividend bit a cycle
                    if (rem_sh >= {1'b0, div_reg}) rem_reg <= 64'(rem_sh - {1'b0, div_reg});
                    else rem_reg <= rem_sh[63:0];
                    quo_reg <= {quo_reg[62:0], 1'b0};
                    bit_reg <= bit_reg + 7'd1;
                    if (bit_reg == 7'd63) st_reg <= ST_POST;
                end
                ST_POST: begin
                    st_reg <= ST_OUT;
                    case (kind_reg)
                        KIND_RANGE: m_tdata <= lo_reg + rem_reg;
                        KIND_CHANCE: m_tuser <= ($signed({1'b0, rem_reg[31:0]}) <
                                                 $signed({prob_reg[31], prob_reg}));
                        KIND_NORMAL: begin
                            acc_reg <= acc_reg + rem_reg;
                            ndraw_reg <= ndraw_reg + 4'd1;
                            if (ndraw_reg == 4'(NORM_DRAWS - 1))
                                m_tdata <= acc_reg + rem_reg - NORM_OFS;
                            else st_reg <= ST_DRAW;
                        end
                        default: m_tdata <= rem_reg;
                    endcase
                end
                ST_RSMUL: if (mul_done) begin
                    // rsph 0: tick product; then salt*(i+1) per stream
                    if (rsph_reg == 2'd0) acc_reg <= mul_p;
                    else z_reg <= (root_seed_reg ^ mul_p ^ acc_reg) + GOLDEN;
                    if (rsph_reg == 2'd0) begin
                        rsph_reg <= 2'd1;
                        mul_a <= STREAM_SALT;
                        mul_b <= 64'(sidx_reg) + 64'd1;
                        mul_start <= 1'b1;
                    end else st_reg <= ST_MIX0;
                end
                ST_RSMIX: begin
                    state_reg[sidx_reg] <= z_reg;
                    count_reg[sidx_reg] <= '0;
                    if (sidx_reg == SIDX_W'(STREAMS - 1)) st_reg <= ST_OUT;
                    else begin
                        sidx_reg <= sidx_reg + SIDX_W'(1);
                        mul_a <= STREAM_SALT;
                        mul_b <= 64'(sidx_reg) + 64'd2;
                        mul_start <= 1'b1;
                        st_reg <= ST_RSMUL;
                    end
                end
                ST_OUT: begin
                    m_tvalid <= 1'b1;
                    st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != ST_IDLE) |-> !s_tready) else $error("ready while busy");
    a_out_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(st_reg == ST_OUT)) else $error("stray result");
    a_hit_only_chance: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (kind_reg == KIND_CHANCE)) else $error("bad hit");
endmodule

// ----- rtl/msrng_mul.sv -----
// 64x64 low-half multiplier: three 32x32 partial products, one a cycle.
module msrng_mul import msrng_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] prod
);
    logic [63:0] a_reg, b_reg, acc_reg, acc_next;
    logic [2:0]  step_reg;
    logic        busy_reg;
    logic [31:0] pa, pb;
    logic [63:0] pp;

    always_comb begin
        pa = a_reg[31:0];
        pb = b_reg[31:0];
        unique case (step_reg[1:0])
            2'd0: begin pa = a_reg[31:0];  pb = b_reg[31:0];  end
            2'd1: begin pa = a_reg[63:32]; pb = b_reg[31:0];  end
            2'd2: begin pa = a_reg[31:0];  pb = b_reg[63:32]; end
            default: begin pa = a_reg[31:0]; pb = b_reg[31:0]; end
        endcase
        pp = {32'd0, pa} * {32'd0, pb};
        acc_next = acc_reg;
        unique case (step_reg[1:0])
            2'd0: acc_next = pp;
            2'd1, 2'd2: acc_next = acc_reg + {pp[31:0], 32'd0};
            default: acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                a_reg <= op_a;
                b_reg <= op_b;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd2) begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end

    assign prod = acc_reg;
endmodule

// ----- tb/multi_stream_splitmix_rng_tb.sv -----
module multi_stream_splitmix_rng_tb;
    import msrng_pkg::*;

    typedef struct packed {
        logic [63:0] value;
        logic        hit;
    } rng_result_t;

    class rng_scoreboard;
        logic [63:0] root_seed;
        logic [63:0] seed_tick;
        logic [63:0] state_word[STREAMS];
        logic [63:0] draws_made[STREAMS];
        rng_result_t pending[$];
        int          errors;

        function new();
            root_seed = '0;
            seed_tick = '0;
            errors = 0;
            for (int i = 0; i < STREAMS; i++) begin
                state_word[i] = '0;
                draws_made[i] = '0;
            end
        endfunction

        function logic [63:0] scramble(logic [63:0] z);
            z = (z ^ (z >> 30)) * MIX_M1;
            z = (z ^ (z >> 27)) * MIX_M2;
            return z ^ (z >> 31);
        endfunction

        function logic [63:0] next_draw(int s);
            state_word[s] = state_word[s] + GOLDEN;
            draws_made[s] = draws_made[s] + 1;
            return scramble(state_word[s]);
        endfunction

        function void set_reg(logic [0:0] idx, logic [63:0] val);
            if (idx == CFG_ROOT_SEED)
                root_seed = val;
            else
                seed_tick = val;
        endfunction

        // note one accepted request and queue the result it must give
        function void note_request(logic [207:0] d);
            logic [2:0]         kind;
            logic [3:0]         sidx;
            logic signed [63:0] lo;
            logic signed [63:0] hi;
            logic signed [31:0] prob;
            logic [31:0]        cnt;
            logic [63:0]        span;
            logic [63:0]        acc;
            logic [63:0]        x;
            rng_result_t        r;
            int                 s;
            kind = d[2:0];
            sidx = d[6:3];
            lo = d[70:7];
            hi = d[134:71];
            prob = d[166:135];
            cnt = d[198:167];
            s = (sidx >= STREAMS) ? 0 : sidx;
            r = '0;
            case (kind)
                KIND_RAW: r.value = next_draw(s);
                KIND_RANGE: begin
                    if (hi <= lo) begin
                        r.value = lo;
                    end else begin
                        span = hi - lo + 64'd1;
                        x = next_draw(s);
                        r.value = lo + ((span == 0) ? x : x % span);
                    end
                end
                KIND_UNIT: r.value = ((next_draw(s) >> 44) * UNIT_SCALE) >> 20;
                KIND_NORMAL: begin
                    acc = '0;
                    for (int i = 0; i < NORM_DRAWS; i++)
                        acc = acc + next_draw(s) % NORM_MOD;
                    r.value = acc - NORM_OFS;
                end
                KIND_CHANCE: begin
                    if (prob >= UNIT_SCALE)
                        r.hit = 1'b1;
                    else if (prob > 0)
                        r.hit = ((next_draw(s) % UNIT_SCALE) < prob);
                end
                KIND_PICK: begin
                    if (cnt != 0)
                        r.value = next_draw(s) % {32'd0, cnt};
                end
                KIND_RESEED: begin
                    for (int i = 0; i < STREAMS; i++) begin
                        x = root_seed ^ (STREAM_SALT * (i + 1)) ^ (seed_tick * GOLDEN);
                        state_word[i] = scramble(x + GOLDEN);
                        draws_made[i] = '0;
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
            $display("MISMATCH %s: expected %h got %h", what, want, got);
            errors++;
        endtask

        task check_result(logic [63:0] value, logic hit);
            rng_result_t want;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing expected", 0, value);
                return;
            end
            want = pending.pop_front();
            if (value !== want.value)
                report_mismatch("value", want.value, value);
            if (hit !== want.hit)
                report_mismatch("hit", want.hit, hit);
        endtask
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [207:0] s_tdata;   // kind, stream, low_bound, high_bound, probability, pick_count
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // value
    logic         m_tuser;   // hit
    logic         cfg_we;
    logic [0:0]   cfg_index;
    logic [63:0]  cfg_wdata;

    rng_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    longint cycles;

    multi_stream_splitmix_rng dut (.*);

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] edgy64();
        case ($urandom_range(5))
            0: return 64'h8000000000000000;
            1: return 64'h7FFFFFFFFFFFFFFF;
            2: return 64'd0;
            3: return 64'hFFFFFFFFFFFFFFFF;
            4: return {{54{$urandom_range(1)==1}}, 10'($urandom)};
            default: return rand64();
        endcase
    endfunction

    function automatic logic [207:0] pack_req(logic [2:0] kind, logic [3:0] sidx,
            logic [63:0] lo, logic [63:0] hi, logic [31:0] prob, logic [31:0] cnt);
        return {9'd0, cnt, prob, hi, lo, sidx, kind};
    endfunction

    // valid stays high after the accept; a pause in the next call, or drain, drops it
    task automatic send_request(logic [207:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_request(d);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (1100) @(posedge aclk);
    endtask

    // enable stays high across back-to-back writes; the caller drops it
    task automatic write_reg(logic [0:0] idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic random_request();
        logic [2:0]  kind;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [31:0] prob;
        logic [31:0] cnt;
        kind = 3'($urandom_range(7));
        // keep slow normal requests rare
        if (kind == KIND_NORMAL && $urandom_range(3) != 0)
            kind = KIND_RAW;
        lo = edgy64();
        hi = edgy64();
        prob = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1100)) - 50;
        cnt = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(20));
        send_request(pack_req(kind, 4'($urandom), lo, hi, prob, cnt));
    endtask

    initial begin
        sb = new();
        cycles = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ROOT_SEED;
        cfg_wdata = '0;
        recv_hold = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: unseeded streams first, then the corner cases
        send_request(pack_req(KIND_RAW, 4'd0, 0, 0, 0, 0));
        send_request(pack_req(KIND_RAW, 4'd15, 0, 0, 0, 0));
        send_request(pack_req(KIND_RESEED, 4'd3, 0, 0, 0, 0));
        send_request(pack_req(KIND_RAW, 4'd11, 0, 0, 0, 0));
        send_request(pack_req(KIND_RANGE, 4'd1, 64'd5, 64'd5, 0, 0));
        send_request(pack_req(KIND_RANGE, 4'd1, 64'd9, -64'sd3, 0, 0));
        send_request(pack_req(KIND_RANGE, 4'd2, 64'h8000000000000000,
                              64'h7FFFFFFFFFFFFFFF, 0, 0));
        send_request(pack_req(KIND_RANGE, 4'd2, -64'sd10, 64'd10, 0, 0));
        send_request(pack_req(KIND_UNIT, 4'd12, 0, 0, 0, 0));
        send_request(pack_req(KIND_NORMAL, 4'd4, 0, 0, 0, 0));
        send_request(pack_req(KIND_CHANCE, 4'd5, 0, 0, 32'd1000, 0));
        send_request(pack_req(KIND_CHANCE, 4'd5, 0, 0, 32'h7FFFFFFF, 0));
        send_request(pack_req(KIND_CHANCE, 4'd5, 0, 0, 32'd0, 0));
        send_request(pack_req(KIND_CHANCE, 4'd5, 0, 0, 32'h80000000, 0));
        send_request(pack_req(KIND_CHANCE, 4'd5, 0, 0, 32'd999, 0));
        send_request(pack_req(KIND_CHANCE, 4'd5, 0, 0, 32'd1, 0));
        send_request(pack_req(KIND_PICK, 4'd6, 0, 0, 0, 32'd0));
        send_request(pack_req(KIND_PICK, 4'd6, 0, 0, 0, 32'hFFFFFFFF));
        send_request(pack_req(KIND_PICK, 4'd6, 0, 0, 0, 32'd1));
        send_request(pack_req(3'd7, 4'd7, 0, 0, 0, 0));
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin write_reg(CFG_ROOT_SEED, '1); write_reg(CFG_SEED_TICK, '1); end
                1: begin write_reg(CFG_ROOT_SEED, rand64()); write_reg(CFG_SEED_TICK, 0); end
                2: begin write_reg(CFG_ROOT_SEED, 0); write_reg(CFG_SEED_TICK, rand64()); end
                default: begin
                    write_reg(CFG_ROOT_SEED, rand64());
                    write_reg(CFG_SEED_TICK, rand64());
                end
            endcase
            cfg_we <= 1'b0;
            send_idle_pct = (phase < 2) ? 24 : (phase < 4) ? 86 : 0;
            recv_idle_pct = (phase < 2) ? 86 : (phase < 4) ? 24 : 0;
            send_request(pack_req(KIND_RESEED, 4'($urandom), 0, 0, 0, 0));
            if (phase == 4) begin
                // stall the receiver long enough for the input to back up
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (3000) @(posedge aclk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 150; n++) begin
                random_request();
                if (n == 75) begin
                    s_tvalid <= 1'b0;
                    while (sb.pending.size() != 0)
                        @(posedge aclk);
                end
            end
            drain();
        end

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/msrng_pkg.sv
rtl/msrng_mul.sv
rtl/multi_stream_splitmix_rng.sv
tb/multi_stream_splitmix_rng_tb.sv
